// File: rtl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types, codes and constants of the FAT cluster chain manager.
// ----------------------------------------------------------------------------
package fccm_pkg;

  // Default table depth
  localparam int NUM_CLUSTERS_DEF = 512;

  // Field widths
  localparam int LEN_W   = 24;
  localparam int NEED_W  = LEN_W + 1;
  localparam int CLU_W   = 9;
  localparam int CNT_W   = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 32;

  // Actions
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_END  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BROKEN   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER        = 1'd1;

  // Register reset values
  localparam logic [3:0]  CLUSTER_SIZE_LOG2_RST = 4'd11;
  localparam logic [31:0] END_MARKER_RST        = 32'h0FFF_FFFF;

  // Table contents after reset
  localparam logic [31:0] RESERVED0_VALUE = 32'h0FFF_FFF0;
  localparam logic [31:0] RESERVED1_VALUE = 32'h0FFF_FFFF;
  localparam logic [31:0] ROOT_END_VALUE  = 32'h0FFF_FFFF;

  typedef struct packed {
    logic [1:0]       action;
    logic [CLU_W-1:0] cluster;
    logic [LEN_W-1:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CLU_W-1:0] first_cluster;
    logic [CNT_W-1:0] chain_len;
    logic             chain_end;
    logic             entry_free;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  cluster_size_log2;
    logic [31:0] end_marker;
  } cfg_t;

  // Engine handshake toward the top level
  typedef struct packed {
    logic ready;  // idle, can take a request beat
    logic done;   // result waiting in the engine
  } eng_stat_t;

endpackage

// File: rtl/fat_cluster_chain_manager_top.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_top
// File allocation table with chain allocate, free and next-entry lookup.
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  action, cluster, byte_length
//   rsp      out        rsp_valid / rsp_stall  status, first_cluster, chain_len, flags
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// One request at a time. Next reads one entry; free reads and clears each
// chain entry in turn; allocate checks the start entry and free count, then
// scans (one table entry checked per cycle, ending at the last pick or the
// table end); an out of range cluster, a reserved one for free, or the unused
// action is answered at once. A new request can be taken in the cycle after the
// result reaches the output register. After reset the table is initialized
// with req_stall high. A stalled rsp beat holds in the output register; the
// engine takes a new request meanwhile and waits only to hand its result over.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager_top #(
  parameter int NUM_CLUSTERS = fccm_pkg::NUM_CLUSTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  fccm_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output fccm_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [fccm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fccm_pkg::CFG_W-1:0]          cfg_data
);
  import fccm_pkg::*;

  cfg_t      cfg;
  eng_stat_t stat;
  rsp_t      res;
  logic      res_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cluster_size_log2 <= CLUSTER_SIZE_LOG2_RST;
      cfg.end_marker        <= END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLUSTER_SIZE_LOG2: cfg.cluster_size_log2 <= cfg_data[3:0];
        REG_END_MARKER:        cfg.end_marker        <= cfg_data;
        default: ;
      endcase
    end
  end

  fccm_engine #(
    .NUM_CLUSTERS(NUM_CLUSTERS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  assign req_stall = !stat.ready;
  assign res_ready = !rsp_valid || !rsp_stall;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && res_ready) begin
      rsp <= res;
    end
  end

endmodule

// File: rtl/fccm_engine.sv
// ----------------------------------------------------------------------------
// fccm_engine
// Allocation table memory and the sequencer that allocates, frees and reads
// cluster chains through read-modify-write of that memory.
// ----------------------------------------------------------------------------
module fccm_engine #(
  parameter int NUM_CLUSTERS = fccm_pkg::NUM_CLUSTERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fccm_pkg::cfg_t       cfg,
  input  logic                 req_valid,
  input  fccm_pkg::req_t       req,
  input  logic                 res_ready,
  output fccm_pkg::eng_stat_t  stat,
  output fccm_pkg::rsp_t       res
);
  import fccm_pkg::*;

  localparam int AW = $clog2(NUM_CLUSTERS);
  localparam int FW = $clog2(NUM_CLUSTERS + 1);
  localparam logic [31:0] NUM32 = 32'(NUM_CLUSTERS);
  localparam logic [AW:0] NUM_X = (AW+1)'(NUM_CLUSTERS);

  // Sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_PCHK = 4'd2;
  localparam logic [3:0] S_A_SCAN = 4'd3;
  localparam logic [3:0] S_A_END  = 4'd4;
  localparam logic [3:0] S_F_RD   = 4'd5;
  localparam logic [3:0] S_F_CHK  = 4'd6;
  localparam logic [3:0] S_N_CHK  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]        state;
  logic [AW-1:0]     cur;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] left;
  logic [AW:0]       scan_idx;
  logic [AW-1:0]     data_idx;
  logic              rd_v;
  logic              have;
  logic [AW-1:0]     prev;
  logic [AW-1:0]     first;
  logic [FW-1:0]     count;
  logic [FW-1:0]     free_cnt;

  // Memory ports
  logic [31:0]   mem [NUM_CLUSTERS];
  logic [31:0]   rdata;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  // Result with only a status code set
  function automatic rsp_t status_res(logic [1:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  // Request decode
  logic [31:0]       req_c32;
  logic              req_in_range;
  logic [AW-1:0]     req_addr;
  logic [NEED_W-1:0] len_ext;
  logic [NEED_W-1:0] round_up;
  logic [NEED_W-1:0] need_calc;
  logic              take;

  assign req_c32      = 32'(req.cluster);
  assign req_in_range = req_c32 < NUM32;
  assign req_addr     = req_c32[AW-1:0];
  assign len_ext      = NEED_W'(req.byte_length);
  assign round_up     = (NEED_W'(1) << cfg.cluster_size_log2) - NEED_W'(1);
  assign need_calc    = (req.byte_length == '0) ? NEED_W'(1)
                      : (len_ext + round_up) >> cfg.cluster_size_log2;
  assign take         = req_valid && (state == S_IDLE);

  // Entry classification
  logic          e_is_end;
  logic          e_zero;
  logic          e_bad;
  logic          scan_hit;
  logic          f_stop;
  logic          f_broken;
  logic [FW-1:0] count_inc;
  logic [31:0]   first32;

  assign e_is_end  = rdata == cfg.end_marker;
  assign e_zero    = rdata == 32'd0;
  assign e_bad     = (rdata < 32'd2) || (rdata >= NUM32);
  assign scan_hit  = rd_v && (left != '0) && e_zero;
  // a free clears exactly the nonzero entries it visits
  assign f_stop    = e_is_end || e_zero || e_bad;
  assign f_broken  = !e_is_end && (e_zero || e_bad);
  assign count_inc = count + FW'(!e_zero);
  assign first32   = 32'(first);

  // Read address
  always_comb begin
    case (state)
      S_IDLE:   ra = req_addr;
      S_A_SCAN: ra = scan_idx[AW-1:0];
      default:  ra = cur;
    endcase
  end

  // Write port
  always_comb begin
    we = 1'b0;
    wa = cur;
    wd = 32'd0;
    case (state)
      S_CLR: begin
        we = 1'b1;
        wa = scan_idx[AW-1:0];
        if (scan_idx == (AW+1)'(0)) begin
          wd = RESERVED0_VALUE;
        end else if (scan_idx == (AW+1)'(1)) begin
          wd = RESERVED1_VALUE;
        end else if (scan_idx == (AW+1)'(2)) begin
          wd = ROOT_END_VALUE;
        end
      end
      S_A_SCAN: begin
        // link previous pick to this one
        we = scan_hit && have;
        wa = prev;
        wd = 32'(data_idx);
      end
      S_A_END: begin
        we = have;
        wa = prev;
        wd = cfg.end_marker;
      end
      S_F_CHK: begin
        we = !e_zero;
        wa = cur;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      scan_idx <= '0;
      free_cnt <= FW'(NUM_CLUSTERS - 3);
      rd_v     <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          scan_idx <= scan_idx + (AW+1)'(1);
          if (scan_idx == NUM_X - (AW+1)'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur   <= req_addr;
            need  <= need_calc;
            left  <= need_calc;
            count <= '0;
            have  <= 1'b0;
            case (req.action)
              ACT_ALLOC: begin
                if (!req_in_range) begin
                  res   <= status_res(ST_NOT_END);
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_A_PCHK;
                end
              end
              ACT_FREE: begin
                if (!req_in_range || req_c32 < 32'd2) begin
                  res   <= status_res(ST_BROKEN);
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_F_CHK;
                end
              end
              ACT_NEXT: begin
                if (!req_in_range) begin
                  res   <= status_res(ST_BROKEN);
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_N_CHK;
                end
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_A_PCHK: begin
          if (!e_is_end) begin
            res.status <= ST_NOT_END;
            state      <= S_DONE;
          end else if (need > NEED_W'(free_cnt)) begin
            res.status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            scan_idx <= (AW+1)'(2);
            rd_v     <= 1'b0;
            state    <= S_A_SCAN;
          end
        end
        S_A_SCAN: begin
          // one read issued and one entry checked per cycle
          rd_v     <= scan_idx < NUM_X;
          data_idx <= scan_idx[AW-1:0];
          if (scan_idx < NUM_X) begin
            scan_idx <= scan_idx + (AW+1)'(1);
          end
          if (scan_hit) begin
            if (!have) begin
              first <= data_idx;
            end
            have <= 1'b1;
            prev <= data_idx;
            left <= left - NEED_W'(1);
          end
          if ((scan_hit && left == NEED_W'(1)) || (!rd_v && scan_idx >= NUM_X)) begin
            state <= S_A_END;
          end
        end
        S_A_END: begin
          rd_v <= 1'b0;
          if (have) begin
            free_cnt <= free_cnt - FW'(need) + FW'(cfg.end_marker == 32'd0);
          end
          res.status        <= ST_OK;
          res.first_cluster <= first32[CLU_W-1:0];
          res.chain_len     <= need[CNT_W-1:0];
          state             <= S_DONE;
        end
        S_F_RD: begin
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          count <= count_inc;
          if (f_stop) begin
            free_cnt      <= free_cnt + count_inc;
            res.status    <= f_broken ? ST_BROKEN : ST_OK;
            res.chain_len <= CNT_W'(count_inc);
            state         <= S_DONE;
          end else begin
            cur   <= rdata[AW-1:0];
            state <= S_F_RD;
          end
        end
        S_N_CHK: begin
          res.first_cluster <= e_is_end ? '0 : rdata[CLU_W-1:0];
          res.chain_end     <= e_is_end;
          res.entry_free    <= e_zero;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.ready = state == S_IDLE;
  assign stat.done  = state == S_DONE;

endmodule
